// ===== rtl/core/length_prefixed_frame_deframer_unit_assert.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define LPFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpfd same-cycle check failed");

// Next-cycle implication, ignored while reset is asserted.
`define LPFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpfd next-cycle check failed");

`endif

// ===== rtl/core/lpfd_pkg.sv =====
// Shared types and constants of the length-prefixed frame deframer.
`timescale 1ns / 1ps
package lpfd_pkg;

    localparam int unsigned HDR_BYTES = 6;
    localparam logic [31:0] MAX_LEN_RESET = 32'd4194304;

    // Header byte positions (little-endian type, then little-endian length).
    localparam logic [2:0] HDR_TYPE_LO = 3'd0;
    localparam logic [2:0] HDR_TYPE_HI = 3'd1;
    localparam logic [2:0] HDR_LEN_B0  = 3'd2;
    localparam logic [2:0] HDR_LEN_B1  = 3'd3;
    localparam logic [2:0] HDR_LEN_B2  = 3'd4;
    localparam logic [2:0] HDR_LEN_B3  = 3'd5;

    typedef struct packed {
        logic [15:0] frame_type;
        logic [7:0]  payload_byte;
        logic        has_byte;
        logic        frame_last;
        logic        oversize_error;
    } t_result;

endpackage

// ===== rtl/core/lpfd_front.sv =====
// Front end: header parser, payload counter and result classification.
`timescale 1ns / 1ps
module lpfd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [7:0]       i_rx_byte,
    input  logic             i_q_full,
    input  logic             i_cfg_valid,
    input  logic [31:0]      i_cfg_data,
    output logic             o_in_stall,
    output logic             o_push,
    output lpfd_pkg::t_result o_result
);
    import lpfd_pkg::*;

    logic [2:0]  r_hdr_idx,    n_hdr_idx;
    logic [15:0] r_type,       n_type;
    logic [31:0] r_remaining,  n_remaining;
    logic        r_in_payload, n_in_payload;
    logic        r_dead,       n_dead;
    logic [31:0] r_max_len,    n_max_len;

    logic        w_accept;
    logic [31:0] w_len;
    logic        w_push;
    t_result     w_result;

    assign o_in_stall = i_q_full;
    assign w_accept   = i_in_valid && !i_q_full;
    // Full length as it stands once the last length byte arrives.
    assign w_len      = {i_rx_byte, r_remaining[23:0]};

    always_comb begin
        n_hdr_idx    = r_hdr_idx;
        n_type       = r_type;
        n_remaining  = r_remaining;
        n_in_payload = r_in_payload;
        n_dead       = r_dead;
        n_max_len    = r_max_len;
        w_push       = 1'b0;
        w_result     = '0;
        w_result.frame_type = r_type;

        if (i_cfg_valid) begin
            n_max_len = i_cfg_data;
        end

        if (w_accept && !r_dead) begin
            if (r_in_payload) begin
                n_remaining           = r_remaining - 32'd1;
                w_push                = 1'b1;
                w_result.payload_byte = i_rx_byte;
                w_result.has_byte     = 1'b1;
                w_result.frame_last   = (r_remaining == 32'd1);
                if (r_remaining == 32'd1) begin
                    n_in_payload = 1'b0;
                    n_hdr_idx    = HDR_TYPE_LO;
                end
            end else begin
                case (r_hdr_idx)
                    HDR_TYPE_LO: begin
                        n_type      = {8'h00, i_rx_byte};
                        n_remaining = '0;
                        n_hdr_idx   = HDR_TYPE_HI;
                    end
                    HDR_TYPE_HI: begin
                        n_type    = {i_rx_byte, r_type[7:0]};
                        n_hdr_idx = HDR_LEN_B0;
                    end
                    HDR_LEN_B0: begin
                        n_remaining = {r_remaining[31:8], i_rx_byte};
                        n_hdr_idx   = HDR_LEN_B1;
                    end
                    HDR_LEN_B1: begin
                        n_remaining = {r_remaining[31:16], i_rx_byte, r_remaining[7:0]};
                        n_hdr_idx   = HDR_LEN_B2;
                    end
                    HDR_LEN_B2: begin
                        n_remaining = {r_remaining[31:24], i_rx_byte, r_remaining[15:0]};
                        n_hdr_idx   = HDR_LEN_B3;
                    end
                    HDR_LEN_B3: begin
                        n_hdr_idx = HDR_TYPE_LO;
                        if (w_len > r_max_len) begin
                            // oversize: report once, then drop everything
                            n_dead                  = 1'b1;
                            n_remaining             = '0;
                            w_push                  = 1'b1;
                            w_result.oversize_error = 1'b1;
                        end else if (w_len == 32'd0) begin
                            n_remaining         = '0;
                            w_push              = 1'b1;
                            w_result.frame_last = 1'b1;
                        end else begin
                            n_remaining  = w_len;
                            n_in_payload = 1'b1;
                        end
                    end
                    default: begin
                        n_hdr_idx = HDR_TYPE_LO;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx    <= HDR_TYPE_LO;
            r_type       <= '0;
            r_remaining  <= '0;
            r_in_payload <= 1'b0;
            r_dead       <= 1'b0;
            r_max_len    <= MAX_LEN_RESET;
        end else begin
            r_hdr_idx    <= n_hdr_idx;
            r_type       <= n_type;
            r_remaining  <= n_remaining;
            r_in_payload <= n_in_payload;
            r_dead       <= n_dead;
            r_max_len    <= n_max_len;
        end
    end

    assign o_push   = w_push;
    assign o_result = w_result;

`include "length_prefixed_frame_deframer_unit_assert.svh"

    `LPFD_ASSERT_NEXT(a_dead_sticks, i_clk, i_rst_n, r_dead, r_dead)
    `LPFD_ASSERT_NOW(a_no_push_dead, i_clk, i_rst_n, r_dead, !w_push)
    `LPFD_ASSERT_NOW(a_payload_hdr_idle, i_clk, i_rst_n, r_in_payload,
                     r_hdr_idx == HDR_TYPE_LO && r_remaining != 32'd0)

endmodule

// ===== rtl/core/lpfd_queue.sv =====
// Short result queue between the parser and the output stage.
`timescale 1ns / 1ps
module lpfd_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lpfd_pkg::t_result i_data,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output lpfd_pkg::t_result o_head
);
    import lpfd_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_result           r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count,  n_count;

    logic w_do_push, w_do_pop;

    assign o_full    = (r_count == FULL_CNT);
    assign o_empty   = (r_count == '0);
    assign o_head    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`include "length_prefixed_frame_deframer_unit_assert.svh"

    `LPFD_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT)
    `LPFD_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `LPFD_ASSERT_NEXT(a_count_grows, i_clk, i_rst_n, w_do_push && !w_do_pop,
                      r_count == $past(r_count) + 1'b1)

endmodule

// ===== rtl/core/lpfd_back.sv =====
// Back end: output register that drains the queue toward the receiver.
`timescale 1ns / 1ps
module lpfd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  lpfd_pkg::t_result i_q_head,
    input  logic              i_out_stall,
    output logic              o_pop,
    output logic              o_out_valid,
    output lpfd_pkg::t_result o_result
);
    import lpfd_pkg::*;

    logic    r_valid, n_valid;
    t_result r_result;
    logic    w_load;

    // Register can take a new entry when empty or being drained this cycle.
    assign w_load  = !r_valid || !i_out_stall;
    assign o_pop   = w_load && !i_q_empty;
    assign n_valid = w_load ? !i_q_empty : r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= i_q_head;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

// ===== rtl/core/length_prefixed_frame_deframer_unit.sv =====
// Top level of the length-prefixed frame deframer.
`timescale 1ns / 1ps
// Usage:
//   Input channel: one stream byte per request on i_rx_byte, i_in_valid with
//   o_in_stall. Each frame is a 6-byte header (16-bit LE type, 32-bit LE
//   length) followed by the payload bytes.
//   Output channel: one result per payload byte, tagged with the frame type
//   and marked last on the final byte; an empty frame gives one result with
//   has_byte low and frame_last high; an oversize length gives one result
//   with o_oversize_error high, after which all input is dropped until reset.
//   Config channel: i_cfg_valid/o_cfg_ready writes max_payload_len
//   (always ready; write only while the block is idle).
// Timing: one byte accepted per clock while o_in_stall is low. A result
//   leaves the parser into the queue at the accept edge, then moves into
//   the output register, where o_out_valid shows it to the receiver.
//   Only the last header byte gives a result (empty or oversize frame).
// Stall: the output register holds while i_out_stall is high; the queue of
//   QUEUE_DEPTH results absorbs the backlog, and o_in_stall rises only once
//   it is full.
// Reset (synchronous, i_rst_n low): parser back to header start, stream
//   revived, queue and output emptied, max_payload_len back to 4 MiB.
module length_prefixed_frame_deframer_unit #(
    parameter int unsigned QUEUE_DEPTH = 4   // 2 or more
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_frame_type,
    output logic [7:0]  o_payload_byte,
    output logic        o_has_byte,
    output logic        o_frame_last,
    output logic        o_oversize_error,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);
    import lpfd_pkg::*;

    logic    w_push, w_pop, w_q_full, w_q_empty;
    t_result w_front_res, w_q_head, w_out_res;

    assign o_cfg_ready = 1'b1;

    // Front: accept bytes, parse headers, turn payload bytes and frame events into results.
    lpfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_rx_byte   (i_rx_byte),
        .i_q_full    (w_q_full),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_in_stall  (o_in_stall),
        .o_push      (w_push),
        .o_result    (w_front_res)
    );

    // Queue decouples parser stalls from receiver stalls.
    lpfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_res),
        .i_pop   (w_pop),
        .o_full  (w_q_full),
        .o_empty (w_q_empty),
        .o_head  (w_q_head)
    );

    // Back: registered output stage.
    lpfd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_q_empty),
        .i_q_head    (w_q_head),
        .i_out_stall (i_out_stall),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_result    (w_out_res)
    );

    assign o_frame_type     = w_out_res.frame_type;
    assign o_payload_byte   = w_out_res.payload_byte;
    assign o_has_byte       = w_out_res.has_byte;
    assign o_frame_last     = w_out_res.frame_last;
    assign o_oversize_error = w_out_res.oversize_error;

endmodule
